@@ design/brcc_pkg.sv @@
package brcc_pkg;

  localparam logic [2:0] KIND_HDR_OK  = 3'd0;
  localparam logic [2:0] KIND_HDR_BAD = 3'd1;
  localparam logic [2:0] KIND_DATA    = 3'd2;
  localparam logic [2:0] KIND_CRC_OK  = 3'd3;
  localparam logic [2:0] KIND_CRC_BAD = 3'd4;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [15:0] BOM_SWAPPED = 16'hAA55;

  // Magic bytes, first byte in the low lane.
  localparam logic [63:0] MAGIC_SEQ = {8'd3, 8'd77, 8'd67, 8'd82, 8'd68, 8'd80, 8'd83, 8'd137};

  // Reflected CRC-32, one byte; flattens to an XOR network.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ design/block_record_crc_checker_top.sv @@
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_stall_o | byte_in_i
// out     | output    | out_valid_o/out_stall_i | kind_o, data_byte_o, bom_swapped_o,
//         |           |                       | class_id_o, major_version_o, minor_version_o,
//         |           |                       | record_data_id_o, record_length_o
// One byte is taken per cycle unless stalled; any result shows on the next cycle from the
// output register. The parser and the byte-wide CRC sit between the input and that register.
// Reset puts the parser back at the first magic byte with the output empty.
// The input is stalled only while a held result is itself stalled.
module block_record_crc_checker_top #(
  parameter int DataIdBytes = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        bom_swapped_o,
  output logic [15:0] class_id_o,
  output logic [7:0]  major_version_o,
  output logic [7:0]  minor_version_o,
  output logic [31:0] record_data_id_o,
  output logic [31:0] record_length_o
);
  import brcc_pkg::*;

  localparam logic [3:0] PH_MAGIC = 4'd0;
  localparam logic [3:0] PH_BOM   = 4'd1;
  localparam logic [3:0] PH_LEN   = 4'd2;
  localparam logic [3:0] PH_CLASS = 4'd3;
  localparam logic [3:0] PH_MAJOR = 4'd4;
  localparam logic [3:0] PH_MINOR = 4'd5;
  localparam logic [3:0] PH_DID   = 4'd6;
  localparam logic [3:0] PH_DATA  = 4'd7;
  localparam logic [3:0] PH_CRC   = 4'd8;
  localparam logic [3:0] PH_DEAD  = 4'd9;

  logic [3:0]  phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic [15:0] class_q, class_d;
  logic [7:0]  major_q, major_d;
  logic [7:0]  minor_q, minor_d;
  logic [31:0] did_q, did_d;
  logic [31:0] crc_q, crc_d;
  logic [23:0] rcv_q, rcv_d;
  logic        bad_q, bad_d;
  logic [7:0]  bom_lo_q, bom_lo_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic        swap_q, swap_d;
  logic [15:0] oclass_q, oclass_d;
  logic [7:0]  omajor_q, omajor_d;
  logic [7:0]  ominor_q, ominor_d;
  logic [31:0] odid_q, odid_d;
  logic [31:0] olen_q, olen_d;

  logic        accept;
  logic        res_valid;
  logic [2:0]  res_kind;
  logic [7:0]  res_data;
  logic        res_swap;
  logic        res_rec;
  logic [31:0] cnt_inc;
  logic [31:0] rcv_full;
  logic        mag_mismatch;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign cnt_inc    = cnt_q + 32'd1;
  assign rcv_full   = {byte_in_i, rcv_q};
  assign mag_mismatch = byte_in_i != MAGIC_SEQ[cnt_q[2:0]*8 +: 8];

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    class_d  = class_q;
    major_d  = major_q;
    minor_d  = minor_q;
    did_d    = did_q;
    crc_d    = crc_q;
    rcv_d    = rcv_q;
    bad_d    = bad_q;
    bom_lo_d = bom_lo_q;
    res_valid = 1'b0;
    res_kind  = KIND_HDR_OK;
    res_data  = 8'h0;
    res_swap  = 1'b0;
    res_rec   = 1'b0;
    unique case (phase_q)
      PH_MAGIC: begin
        bad_d = bad_q | mag_mismatch;
        if (cnt_q >= 32'd7) begin
          cnt_d = '0;
          if (bad_d) begin
            phase_d   = PH_DEAD;
            res_valid = 1'b1;
            res_kind  = KIND_HDR_BAD;
          end else begin
            phase_d = PH_BOM;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_BOM: begin
        if (cnt_q == '0) begin
          bom_lo_d = byte_in_i;
          cnt_d    = 32'd1;
        end else begin
          cnt_d     = '0;
          phase_d   = PH_LEN;
          crc_d     = CRC_INIT;
          res_valid = 1'b1;
          res_kind  = KIND_HDR_OK;
          res_swap  = {byte_in_i, bom_lo_q} == BOM_SWAPPED;
        end
      end
      PH_LEN: begin
        if (cnt_q == '0) len_d = '0;
        len_d[cnt_q[1:0]*8 +: 8] = byte_in_i;
        if (cnt_q >= 32'd3) begin
          cnt_d   = '0;
          phase_d = PH_CLASS;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_CLASS: begin
        if (cnt_q == '0) begin
          class_d = {8'h0, byte_in_i};
          cnt_d   = 32'd1;
        end else begin
          class_d = {byte_in_i, class_q[7:0]};
          cnt_d   = '0;
          phase_d = PH_MAJOR;
        end
      end
      PH_MAJOR: begin
        major_d = byte_in_i;
        phase_d = PH_MINOR;
      end
      PH_MINOR: begin
        // ID word enters low byte first: minor, major, class low, class high
        minor_d = byte_in_i;
        crc_d   = crc32_byte(crc32_byte(crc32_byte(crc32_byte(CRC_INIT, byte_in_i),
                  major_q), class_q[7:0]), class_q[15:8]);
        did_d   = '0;
        cnt_d   = '0;
        phase_d = PH_DID;
      end
      PH_DID: begin
        if (cnt_q < 32'd4) did_d[cnt_q[1:0]*8 +: 8] = byte_in_i;
        crc_d = crc32_byte(crc_q, byte_in_i);
        cnt_d = cnt_inc;
        if (cnt_inc >= 32'(DataIdBytes)) begin
          cnt_d   = '0;
          phase_d = (len_q == '0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_d = crc32_byte(crc_q, byte_in_i);
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          cnt_d   = '0;
          phase_d = PH_CRC;
        end
        res_valid = 1'b1;
        res_kind  = KIND_DATA;
        res_data  = byte_in_i;
      end
      PH_CRC: begin
        // first three CRC bytes shift in from the top; the fourth joins them directly
        if (cnt_q < 32'd3) begin
          rcv_d = {byte_in_i, rcv_q[23:8]};
          cnt_d = cnt_inc;
        end else begin
          cnt_d     = '0;
          phase_d   = PH_LEN;
          crc_d     = CRC_INIT;
          res_valid = 1'b1;
          res_rec   = 1'b1;
          res_kind  = (rcv_full == ~crc_q) ? KIND_CRC_OK : KIND_CRC_BAD;
        end
      end
      PH_DEAD: begin
      end
      default: begin
        phase_d = PH_DEAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    kind_d      = kind_q;
    data_d      = data_q;
    swap_d      = swap_q;
    oclass_d    = oclass_q;
    omajor_d    = omajor_q;
    ominor_d    = ominor_q;
    odid_d      = odid_q;
    olen_d      = olen_q;
    if (accept) begin
      out_valid_d = res_valid;
      kind_d      = res_kind;
      data_d      = res_data;
      swap_d      = res_swap;
      oclass_d    = res_rec ? class_q : 16'h0;
      omajor_d    = res_rec ? major_q : 8'h0;
      ominor_d    = res_rec ? minor_q : 8'h0;
      odid_d      = res_rec ? did_q : 32'h0;
      olen_d      = res_rec ? len_q : 32'h0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC;
      cnt_q       <= '0;
      len_q       <= '0;
      class_q     <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      did_q       <= '0;
      crc_q       <= CRC_INIT;
      rcv_q       <= '0;
      bad_q       <= 1'b0;
      bom_lo_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        len_q    <= len_d;
        class_q  <= class_d;
        major_q  <= major_d;
        minor_q  <= minor_d;
        did_q    <= did_d;
        crc_q    <= crc_d;
        rcv_q    <= rcv_d;
        bad_q    <= bad_d;
        bom_lo_q <= bom_lo_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    data_q   <= data_d;
    swap_q   <= swap_d;
    oclass_q <= oclass_d;
    omajor_q <= omajor_d;
    ominor_q <= ominor_d;
    odid_q   <= odid_d;
    olen_q   <= olen_d;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign data_byte_o      = data_q;
  assign bom_swapped_o    = swap_q;
  assign class_id_o       = oclass_q;
  assign major_version_o  = omajor_q;
  assign minor_version_o  = ominor_q;
  assign record_data_id_o = odid_q;
  assign record_length_o  = olen_q;

endmodule

@@ tb/block_record_crc_checker_top_test.sv @@
`timescale 1ns / 1ps

module block_record_crc_checker_top_test;
  import brcc_pkg::*;

  localparam int DID_BYTES = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTES_PER_PHASE = 475;

  typedef enum logic [3:0] {
    P_MAGIC, P_MARK, P_LEN, P_CLASS, P_MAJOR, P_MINOR, P_DID, P_PAYLOAD, P_CRC, P_DEAD
  } parse_state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        bom_swapped;
    logic [15:0] class_id;
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [31:0] data_id;
    logic [31:0] length;
  } rec_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] byte_in = 8'h00;
  logic out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic        bom_swapped;
  logic [15:0] class_id;
  logic [7:0]  major_version;
  logic [7:0]  minor_version;
  logic [31:0] record_data_id;
  logic [31:0] record_length;

  logic [7:0] byte_stream_q[$];
  rec_event_t expected_events_q[$];

  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_fail = 0;
  int n_cycles = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_off = 1'b0;
  int src_pct [4] = '{0, 63, 0, 34};
  int sink_pct [4] = '{0, 0, 63, 34};

  // parser state mirrored by the testbench
  parse_state_e rd_state = P_MAGIC;
  logic [31:0] rd_count = '0;
  logic [31:0] rec_len = '0;
  logic [15:0] rec_class = '0;
  logic [7:0]  rec_major = '0;
  logic [7:0]  rec_minor = '0;
  logic [31:0] rec_did = '0;
  logic [31:0] rec_crc = CRC_INIT;
  logic [31:0] rx_crc = '0;
  logic        magic_err = 1'b0;
  logic [7:0]  mark_lo = '0;

  block_record_crc_checker_top #(
    .DataIdBytes(DID_BYTES)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .byte_in_i       (byte_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kind_o          (kind),
    .data_byte_o     (data_byte),
    .bom_swapped_o   (bom_swapped),
    .class_id_o      (class_id),
    .major_version_o (major_version),
    .minor_version_o (minor_version),
    .record_data_id_o(record_data_id),
    .record_length_o (record_length)
  );

  always #5 clk_i = ~clk_i;

  // bit-serial reflected CRC-32, data bits LSB first
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic fb;
    r = c;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    byte_stream_q.push_back(b);
    n_queued++;
  endtask

  // n_pay below len leaves the record open at the end of the stream
  task automatic queue_record(input logic [15:0] cls, input logic [7:0] maj,
                              input logic [7:0] mnr, input logic [31:0] did,
                              input logic [31:0] len, input int unsigned n_pay,
                              input bit corrupt);
    logic [31:0] crc;
    logic [7:0] b;
    for (int i = 0; i < 4; i++) put_byte(len[8*i +: 8]);
    put_byte(cls[7:0]);
    put_byte(cls[15:8]);
    put_byte(maj);
    put_byte(mnr);
    crc = crc32_step(CRC_INIT, mnr);
    crc = crc32_step(crc, maj);
    crc = crc32_step(crc, cls[7:0]);
    crc = crc32_step(crc, cls[15:8]);
    for (int i = 0; i < DID_BYTES; i++) begin
      b = 8'(did >> (8 * i));
      put_byte(b);
      crc = crc32_step(crc, b);
    end
    for (int unsigned i = 0; i < n_pay; i++) begin
      b = 8'($urandom);
      put_byte(b);
      crc = crc32_step(crc, b);
    end
    if (n_pay == len) begin
      crc = ~crc;
      if (corrupt) crc = crc ^ (32'd1 << $urandom_range(31));
      for (int i = 0; i < 4; i++) put_byte(crc[8*i +: 8]);
    end
  endtask

  // advance the mirrored parser by one accepted byte
  task automatic parse_byte(input logic [7:0] b);
    rec_event_t ev;
    ev = '0;
    case (rd_state)
      P_MAGIC: begin
        if (b != MAGIC_SEQ[8*rd_count[2:0] +: 8]) magic_err = 1'b1;
        if (rd_count >= 7) begin
          rd_count = 0;
          if (magic_err) begin
            rd_state = P_DEAD;
            ev.kind = KIND_HDR_BAD;
            expected_events_q.push_back(ev);
          end else begin
            rd_state = P_MARK;
          end
        end else begin
          rd_count++;
        end
      end
      P_MARK: begin
        if (rd_count == 0) begin
          mark_lo = b;
          rd_count = 1;
        end else begin
          rd_count = 0;
          rd_state = P_LEN;
          rec_crc = CRC_INIT;
          ev.kind = KIND_HDR_OK;
          ev.bom_swapped = ({b, mark_lo} == BOM_SWAPPED);
          expected_events_q.push_back(ev);
        end
      end
      P_LEN: begin
        if (rd_count == 0) rec_len = '0;
        rec_len = rec_len | (32'(b) << (8 * rd_count[1:0]));
        if (rd_count >= 3) begin
          rd_count = 0;
          rd_state = P_CLASS;
        end else begin
          rd_count++;
        end
      end
      P_CLASS: begin
        if (rd_count == 0) begin
          rec_class = {8'h00, b};
          rd_count = 1;
        end else begin
          rec_class[15:8] = b;
          rd_count = 0;
          rd_state = P_MAJOR;
        end
      end
      P_MAJOR: begin
        rec_major = b;
        rd_state = P_MINOR;
      end
      P_MINOR: begin
        rec_minor = b;
        rec_crc = crc32_step(CRC_INIT, rec_minor);
        rec_crc = crc32_step(rec_crc, rec_major);
        rec_crc = crc32_step(rec_crc, rec_class[7:0]);
        rec_crc = crc32_step(rec_crc, rec_class[15:8]);
        rec_did = '0;
        rd_count = 0;
        rd_state = P_DID;
      end
      P_DID: begin
        if (rd_count < 4) rec_did = rec_did | (32'(b) << (8 * rd_count[1:0]));
        rec_crc = crc32_step(rec_crc, b);
        rd_count++;
        if (rd_count >= DID_BYTES) begin
          rd_count = 0;
          rd_state = (rec_len == 0) ? P_CRC : P_PAYLOAD;
        end
      end
      P_PAYLOAD: begin
        rec_crc = crc32_step(rec_crc, b);
        rd_count++;
        if (rd_count >= rec_len) begin
          rd_count = 0;
          rd_state = P_CRC;
        end
        ev.kind = KIND_DATA;
        ev.data_byte = b;
        expected_events_q.push_back(ev);
      end
      P_CRC: begin
        if (rd_count == 0) rx_crc = '0;
        rx_crc = rx_crc | (32'(b) << (8 * rd_count[1:0]));
        if (rd_count < 3) begin
          rd_count++;
        end else begin
          rd_count = 0;
          rd_state = P_LEN;
          ev.kind = (rx_crc == ~rec_crc) ? KIND_CRC_OK : KIND_CRC_BAD;
          ev.class_id = rec_class;
          ev.major = rec_major;
          ev.minor = rec_minor;
          ev.data_id = rec_did;
          ev.length = rec_len;
          expected_events_q.push_back(ev);
          rec_crc = CRC_INIT;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h", n_checked, what, got, want);
    n_fail++;
  endtask

  task automatic check_result();
    rec_event_t e;
    if (expected_events_q.size() == 0) begin
      report_mismatch("unexpected result, kind", 32'(kind), 32'd0);
    end else begin
      e = expected_events_q.pop_front();
      if (kind !== e.kind) report_mismatch("kind", 32'(kind), 32'(e.kind));
      if (data_byte !== e.data_byte) report_mismatch("data_byte", 32'(data_byte),
                                                     32'(e.data_byte));
      if (bom_swapped !== e.bom_swapped) report_mismatch("bom_swapped", 32'(bom_swapped),
                                                         32'(e.bom_swapped));
      if (class_id !== e.class_id) report_mismatch("class_id", 32'(class_id),
                                                   32'(e.class_id));
      if (major_version !== e.major) report_mismatch("major_version", 32'(major_version),
                                                     32'(e.major));
      if (minor_version !== e.minor) report_mismatch("minor_version", 32'(minor_version),
                                                     32'(e.minor));
      if (record_data_id !== e.data_id) report_mismatch("record_data_id", record_data_id,
                                                        e.data_id);
      if (record_length !== e.length) report_mismatch("record_length", record_length,
                                                       e.length);
    end
    n_checked++;
  endtask

  // driver: a new request goes out only when the current one is taken or none is up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      byte_in <= 8'h00;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(byte_in);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (byte_stream_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          byte_in <= byte_stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= hold_off || ($urandom_range(99) < sink_stall_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin : long_hold
    while (n_accepted < 100) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] mark;
    int unsigned len;
    int phase_start;
    for (int i = 0; i < 8; i++) put_byte(MAGIC_SEQ[8*i +: 8]);
    case ($urandom_range(2))
      0: mark = BOM_SWAPPED;
      1: mark = 16'h55AA;
      default: mark = 16'($urandom);
    endcase
    put_byte(mark[7:0]);
    put_byte(mark[15:8]);
    // zero length, then extreme ids with payload, then a broken CRC
    queue_record(16'h0000, 8'h00, 8'hFF, 32'h0000_0000, 0, 0, 1'b0);
    queue_record(16'hFFFF, 8'hFF, 8'h00, 32'hFFFF_FFFF, 2, 2, 1'b0);
    queue_record(16'h8001, 8'h7F, 8'h80, 32'h8000_0001, 1, 1, 1'b1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct <= src_pct[ph];
      sink_stall_pct <= sink_pct[ph];
      phase_start = n_queued;
      while (n_queued - phase_start < BYTES_PER_PHASE) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(300, 17) : $urandom_range(16);
        queue_record(16'($urandom), 8'($urandom), 8'($urandom), $urandom, len, len,
                     $urandom_range(3) == 0);
      end
      // stream ends inside a record whose length has every bit set
      if (ph == 3) queue_record(16'($urandom), 8'($urandom), 8'($urandom), $urandom,
                                32'hFFFF_FFFF, 40, 1'b0);
      while (byte_stream_q.size() != 0) @(posedge clk_i);
    end

    while (in_valid || byte_stream_q.size() != 0) @(posedge clk_i);
    while (expected_events_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/brcc_pkg.sv
design/block_record_crc_checker_top.sv
tb/block_record_crc_checker_top_test.sv
